// File: rtl/fcg_pkg.sv
package fcg_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_BYTES_PER_SECTOR    = 3'd0;
    localparam logic [2:0] REG_SECTORS_PER_CLUSTER = 3'd1;
    localparam logic [2:0] REG_RESERVED_SECTORS    = 3'd2;
    localparam logic [2:0] REG_FAT_COPIES          = 3'd3;
    localparam logic [2:0] REG_FAT_SIZE_SECTORS    = 3'd4;
    localparam logic [2:0] REG_ROOT_ENTRY_COUNT    = 3'd5;
    localparam logic [2:0] REG_TOTAL_SECTORS       = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Volume type codes.
    localparam logic [1:0] VOL_FAT12 = 2'd0;
    localparam logic [1:0] VOL_FAT16 = 2'd1;
    localparam logic [1:0] VOL_FAT32 = 2'd2;

    localparam logic [31:0] FAT12_LIMIT = 32'd4085;
    localparam logic [31:0] FAT16_LIMIT = 32'd65525;
    localparam logic [27:0] EOC_BOUND   = 28'hFFFFFF8;
    localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;

    // Pipeline layout: one quotient bit per stage for each divider.
    localparam int FAT_STEPS   = 30;
    localparam int RDS_STEPS   = 22;
    localparam int CNT_STEPS   = 32;
    localparam int META_STAGE  = RDS_STEPS + 1;
    localparam int SUM_STAGE   = META_STAGE + 1;
    localparam int CNT_FIRST   = SUM_STAGE + 1;
    localparam int CNT_LAST    = SUM_STAGE + CNT_STEPS;
    localparam int FSEC_STAGE  = FAT_STEPS + 1;
    localparam int TYPE_STAGE  = CNT_LAST + 1;
    localparam int DEPTH       = TYPE_STAGE + 1;

    typedef struct packed {
        logic [27:0] cluster_id;
        logic [31:0] raw_fat_entry;
    } req_t;

    typedef struct packed {
        logic [31:0] cluster_first_sector;
        logic [31:0] fat_sector;
        logic [11:0] entry_offset;
        logic [15:0] root_dir_sector_count;
        logic [31:0] data_region_sectors;
        logic [31:0] cluster_count;
        logic [1:0]  volume_type;
        logic [27:0] next_cluster;
        logic        end_of_chain;
    } rsp_t;

    // Everything one item carries down the pipeline.
    typedef struct packed {
        logic [27:0] cluster;
        logic [27:0] next;
        logic        eoc;
        logic [29:0] fnum;
        logic [13:0] frem;
        logic [29:0] fq;
        logic [21:0] rnum;
        logic [13:0] rrem;
        logic [21:0] rq;
        logic [31:0] fatprod;
        logic [31:0] cprod;
        logic [31:0] meta;
        logic [31:0] first;
        logic [31:0] data;
        logic [31:0] cnum;
        logic [8:0]  crem;
        logic [31:0] cq;
        logic [31:0] fsec;
        logic [11:0] foffs;
        logic [1:0]  vtype;
    } stage_t;

endpackage

// File: rtl/fat32_cluster_geometry_top.sv
// Channel   Handshake        Payload          Notes
// request   start / busy     req   (req_t)    accepted when start is high, busy low
// result    strobe           rsp   (rsp_t)    valid for one cycle, cannot be held off
// config    cfg_we           cfg_index/data   written at the edge, no read-back
//
// A new item is accepted in every cycle and busy is always low.
// The depth is set by the restoring dividers: the root directory count (22 steps)
// feeds the sector sums and then the cluster count divider (32 steps), one quotient
// bit per stage. Reset clears the valid bits of the pipeline and loads the register
// defaults. The receiver cannot stall, so nothing is ever held back.
module fat32_cluster_geometry_top
    import fcg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  req_t                   req,
    output logic                   strobe,
    output rsp_t                   rsp,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [12:0] bps_reg;
    logic [7:0]  spc_reg;
    logic [15:0] rsvd_reg;
    logic [7:0]  copies_reg;
    logic [31:0] fatsz_reg;
    logic [15:0] rec_reg;
    logic [31:0] total_reg;

    stage_t entry;
    stage_t stage_next [DEPTH];
    stage_t stage_reg  [DEPTH];
    logic [DEPTH-1:0] valid_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg    <= 13'd512;
            spc_reg    <= 8'd8;
            rsvd_reg   <= 16'd32;
            copies_reg <= 8'd2;
            fatsz_reg  <= 32'd0;
            rec_reg    <= 16'd0;
            total_reg  <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BYTES_PER_SECTOR:    bps_reg    <= cfg_data[12:0];
                REG_SECTORS_PER_CLUSTER: spc_reg    <= cfg_data[7:0];
                REG_RESERVED_SECTORS:    rsvd_reg   <= cfg_data[15:0];
                REG_FAT_COPIES:          copies_reg <= cfg_data[7:0];
                REG_FAT_SIZE_SECTORS:    fatsz_reg  <= cfg_data;
                REG_ROOT_ENTRY_COUNT:    rec_reg    <= cfg_data[15:0];
                REG_TOTAL_SECTORS:       total_reg  <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Entry stage: load the FAT offset and root directory dividers and form the FAT size product.
    always_comb
    begin
        entry         = '0;
        entry.cluster = req.cluster_id;
        entry.next    = req.raw_fat_entry[27:0];
        entry.eoc     = (req.raw_fat_entry[27:0] >= EOC_BOUND);
        entry.fnum    = {req.cluster_id, 2'b00};
        entry.rnum    = 22'({rec_reg, 5'b00000}) + 22'(bps_reg) - 22'd1;
        entry.fatprod = 32'(32'(copies_reg) * fatsz_reg);
    end

    // Per-stage work; each stage's role is fixed by its position.
    always_comb
    begin
        stage_t      src;
        stage_t      nxt;
        logic [13:0] ftrial;
        logic [13:0] rtrial;
        logic [8:0]  ctrial;
        logic [31:0] diff;
        for (int s = 0; s < DEPTH; s++)
        begin
            if (s == 0)
                src = entry;
            else
                src = stage_reg[s-1];
            nxt = src;
            ftrial = {src.frem[12:0], src.fnum[29]};
            rtrial = {src.rrem[12:0], src.rnum[21]};
            ctrial = {src.crem[7:0], src.cnum[31]};
            diff   = {4'b0000, src.cluster} - FIRST_DATA_CLUSTER;

            // FAT offset divider, one bit per stage.
            if (s >= 1 && s <= FAT_STEPS)
            begin
                nxt.fnum = {src.fnum[28:0], 1'b0};
                if (ftrial >= {1'b0, bps_reg})
                begin
                    nxt.frem = ftrial - {1'b0, bps_reg};
                    nxt.fq   = {src.fq[28:0], 1'b1};
                end
                else
                begin
                    nxt.frem = ftrial;
                    nxt.fq   = {src.fq[28:0], 1'b0};
                end
            end

            // Root directory divider.
            if (s >= 1 && s <= RDS_STEPS)
            begin
                nxt.rnum = {src.rnum[20:0], 1'b0};
                if (rtrial >= {1'b0, bps_reg})
                begin
                    nxt.rrem = rtrial - {1'b0, bps_reg};
                    nxt.rq   = {src.rq[20:0], 1'b1};
                end
                else
                begin
                    nxt.rrem = rtrial;
                    nxt.rq   = {src.rq[20:0], 1'b0};
                end
            end

            // Cluster offset product.
            if (s == 1)
            begin
                nxt.cprod = 32'(diff * 32'(spc_reg));
            end

            // Sectors ahead of the data region.
            if (s == META_STAGE)
            begin
                nxt.meta = 32'(rsvd_reg) + src.fatprod + 32'(src.rq[15:0]);
            end

            // First sector and data region size; load the count divider.
            if (s == SUM_STAGE)
            begin
                nxt.first = src.cprod + src.meta;
                nxt.data  = total_reg - src.meta;
                nxt.cnum  = total_reg - src.meta;
                nxt.crem  = '0;
                nxt.cq    = '0;
            end

            // Cluster count divider.
            if (s >= CNT_FIRST && s <= CNT_LAST)
            begin
                nxt.cnum = {src.cnum[30:0], 1'b0};
                if (ctrial >= {1'b0, spc_reg})
                begin
                    nxt.crem = ctrial - {1'b0, spc_reg};
                    nxt.cq   = {src.cq[30:0], 1'b1};
                end
                else
                begin
                    nxt.crem = ctrial;
                    nxt.cq   = {src.cq[30:0], 1'b0};
                end
            end

            // FAT sector and offset; a zero sector size adds all ones to the reserved count.
            if (s == FSEC_STAGE)
            begin
                if (bps_reg == 13'd0)
                begin
                    nxt.fsec  = 32'(rsvd_reg) + 32'hFFFF_FFFF;
                    nxt.foffs = {src.cluster[9:0], 2'b00};
                end
                else
                begin
                    nxt.fsec  = 32'(rsvd_reg) + {2'b00, src.fq};
                    nxt.foffs = src.frem[11:0];
                end
            end

            // Volume type from the cluster count.
            if (s == TYPE_STAGE)
            begin
                if (src.cq < FAT12_LIMIT)
                    nxt.vtype = VOL_FAT12;
                else if (src.cq < FAT16_LIMIT)
                    nxt.vtype = VOL_FAT16;
                else
                    nxt.vtype = VOL_FAT32;
            end

            stage_next[s] = nxt;
        end
    end

    // Valid bits travel with the items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[DEPTH-2:0], start};
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DEPTH; s++)
        begin
            stage_reg[s] <= stage_next[s];
        end
    end

    // Result item from the last stage.
    assign strobe = valid_reg[DEPTH-1];

    always_comb
    begin
        rsp.cluster_first_sector  = stage_reg[DEPTH-1].first;
        rsp.fat_sector            = stage_reg[DEPTH-1].fsec;
        rsp.entry_offset          = stage_reg[DEPTH-1].foffs;
        rsp.root_dir_sector_count = stage_reg[DEPTH-1].rq[15:0];
        rsp.data_region_sectors   = stage_reg[DEPTH-1].data;
        rsp.cluster_count         = stage_reg[DEPTH-1].cq;
        rsp.volume_type           = stage_reg[DEPTH-1].vtype;
        rsp.next_cluster          = stage_reg[DEPTH-1].next;
        rsp.end_of_chain          = stage_reg[DEPTH-1].eoc;
    end

endmodule
